// File: hdl/tga_rle_pkg.sv
// ---------------------------------------------------------------------------
// TGA RLE decoder package
// Shared constants and register indexes for the TGA pixel stream decoder.
// ---------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RLE_ENABLE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_ENABLE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL    = 2'd3;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_DATA    = 1'b1;

  localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd3;
  localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;
  localparam logic [2:0]  PIXEL_BYTES_MAX   = 3'd4;

  localparam int unsigned RUN_FLAG_BIT   = 7;
  localparam logic [7:0]  RUN_COUNT_MASK = 8'h7f;

endpackage

// File: hdl/tga_rle_palette_decoder.sv
// ---------------------------------------------------------------------------
// TGA RLE palette decoder
// Turns a TGA pixel byte stream into pixels with repeat counts, with
// optional run-length packets and palette lookup.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake          Payload
//   in_      in_valid/in_stall   kind, data_byte, palette_index, palette_entry
//   out_     out_valid/out_stall pixel_value, repeat_res, image_done, clamped
//   cfg_     cfg_valid/cfg_ready index (2 bits), data (32 bits)
//
// One word is accepted per cycle while in_stall is low; a pixel appears on the
// output in the cycle after its last byte is accepted, from the result
// register and the registered palette read.
// Reset clears the decoder state and the registers, but not the palette.
// A result held by out_stall stalls the input, so the input keeps moving
// while the output word is taken every cycle.
module tga_rle_palette_decoder #(
  parameter int unsigned PALETTE_ENTRIES = tga_rle_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [7:0]                         in_data_byte,
  input  logic [7:0]                         in_palette_index,
  input  logic [31:0]                        in_palette_entry,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        out_pixel_value,
  output logic [7:0]                         out_repeat_res,
  output logic                               out_image_done,
  output logic                               out_clamped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import tga_rle_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic [2:0]  pixel_bytes_r;
  logic        rle_enable_r;
  logic        palette_enable_r;
  logic [31:0] pixel_total_r;

  logic        await_r, await_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [31:0] emitted_r, emitted_nxt;

  logic        res_valid_r;
  logic [31:0] res_value_r, res_value_nxt;
  logic [7:0]  res_repeat_r, res_repeat_nxt;
  logic        res_done_r, res_done_nxt;
  logic        res_clamp_r, res_clamp_nxt;
  logic        res_pal_r, res_pal_nxt;
  logic        res_in_range_r, res_in_range_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        res_fire;
  logic [2:0]  width;
  logic [31:0] value;
  logic [31:0] remaining;
  logic [7:0]  left_dec;
  logic        wr_en;
  logic        rd_en;
  logic [31:0] rd_data;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = res_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r    <= PIXEL_BYTES_RESET;
      rle_enable_r     <= 1'b0;
      palette_enable_r <= 1'b0;
      pixel_total_r    <= PIXEL_TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PIXEL_BYTES:    pixel_bytes_r    <= cfg_data[2:0];
        CFG_RLE_ENABLE:     rle_enable_r     <= cfg_data[0];
        CFG_PALETTE_ENABLE: palette_enable_r <= cfg_data[0];
        CFG_PIXEL_TOTAL:    pixel_total_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pixel_bytes_r == 3'd0) begin
      width = 3'd1;
    end else if (pixel_bytes_r > PIXEL_BYTES_MAX) begin
      width = PIXEL_BYTES_MAX;
    end else begin
      width = pixel_bytes_r;
    end
  end

  assign remaining = pixel_total_r - emitted_r;
  assign left_dec  = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
  assign value     = {8'd0, asm_r} | ({24'd0, in_data_byte} << {pos_r, 3'b000});

  always_comb begin
    await_nxt        = await_r;
    run_nxt          = run_r;
    left_nxt         = left_r;
    pos_nxt          = pos_r;
    asm_nxt          = asm_r;
    emitted_nxt      = emitted_r;
    res_fire         = 1'b0;
    res_value_nxt    = value;
    res_repeat_nxt   = 8'd1;
    res_done_nxt     = 1'b0;
    res_clamp_nxt    = 1'b0;
    res_pal_nxt      = palette_enable_r;
    res_in_range_nxt = {1'b0, value[7:0]} < 9'(PALETTE_ENTRIES);
    if (in_acc && in_kind == KIND_DATA && emitted_r < pixel_total_r) begin
      if (rle_enable_r && await_r) begin
        run_nxt   = in_data_byte[RUN_FLAG_BIT];
        left_nxt  = (in_data_byte & RUN_COUNT_MASK) + 8'd1;
        await_nxt = 1'b0;
        pos_nxt   = 2'd0;
        asm_nxt   = 24'd0;
      end else if ({1'b0, pos_r} + 3'd1 < width) begin
        asm_nxt = value[23:0];
        pos_nxt = pos_r + 2'd1;
      end else begin
        pos_nxt  = 2'd0;
        asm_nxt  = 24'd0;
        res_fire = 1'b1;
        if (rle_enable_r) begin
          if (run_r) begin
            res_repeat_nxt = (left_r == 8'd0) ? 8'd1 : left_r;
            left_nxt       = 8'd0;
            await_nxt      = 1'b1;
          end else begin
            left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              await_nxt = 1'b1;
            end
          end
        end
        if ({24'd0, res_repeat_nxt} > remaining) begin
          res_repeat_nxt = remaining[7:0];
          res_clamp_nxt  = 1'b1;
        end
        res_done_nxt = {24'd0, res_repeat_nxt} == remaining;
        emitted_nxt  = emitted_r + {24'd0, res_repeat_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r     <= 1'b1;
      run_r       <= 1'b0;
      left_r      <= 8'd0;
      pos_r       <= 2'd0;
      asm_r       <= 24'd0;
      emitted_r   <= 32'd0;
      res_valid_r <= 1'b0;
    end else begin
      await_r   <= await_nxt;
      run_r     <= run_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      asm_r     <= asm_nxt;
      emitted_r <= emitted_nxt;
      if (res_fire) begin
        res_valid_r <= 1'b1;
      end else if (out_acc) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_value_r    <= res_value_nxt;
      res_repeat_r   <= res_repeat_nxt;
      res_done_r     <= res_done_nxt;
      res_clamp_r    <= res_clamp_nxt;
      res_pal_r      <= res_pal_nxt;
      res_in_range_r <= res_in_range_nxt;
    end
  end

  assign wr_en = in_acc && in_kind == KIND_PALETTE &&
                 {1'b0, in_palette_index} < 9'(PALETTE_ENTRIES);
  assign rd_en = res_fire && palette_enable_r;

  tga_rle_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_palette_index[AW-1:0]),
    .wr_data (in_palette_entry),
    .rd_en   (rd_en),
    .rd_addr (value[AW-1:0]),
    .rd_data (rd_data)
  );

  assign out_valid       = res_valid_r;
  assign out_pixel_value = !res_pal_r     ? res_value_r :
                           res_in_range_r ? rd_data     : 32'd0;
  assign out_repeat_res  = res_repeat_r;
  assign out_image_done  = res_done_r;
  assign out_clamped     = res_clamp_r;

endmodule

// File: hdl/tga_rle_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module tga_rle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: verif/tga_rle_palette_decoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TGA RLE palette decoder testbench
// Feeds palette loads and image bytes through the input channel and checks
// every decoded pixel, in order, against a predictor run on each accepted word
// or a scripted pixel. A short scripted sequence comes first, then random
// segments that each reprogram the registers while the decoder is idle.
// ---------------------------------------------------------------------------
module tga_rle_palette_decoder_tb;
  import tga_rle_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SEGMENTS      = 16;
  localparam int unsigned SEGMENT_WORDS = 26;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  rep_count;
    logic        done;
    logic        clamped;
  } pixel_t;

  typedef enum logic {STEP_WORD, STEP_CONFIG} step_op_t;

  typedef struct packed {
    step_op_t               op;
    logic                   kind;
    logic [7:0]             data_byte;
    logic [7:0]             pal_index;
    logic [31:0]            value;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic                   typed;
    pixel_t                 want;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_kind;
  logic [7:0]             in_data_byte;
  logic [7:0]             in_palette_index;
  logic [31:0]            in_palette_entry;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [31:0]            out_pixel_value;
  logic [7:0]             out_repeat_res;
  logic                   out_image_done;
  logic                   out_clamped;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [31:0] color_table [PALETTE_ENTRIES_DEF];
  logic [2:0]  set_pixel_bytes;
  logic        set_rle;
  logic        set_palette;
  logic [31:0] set_total;
  logic        hdr_pending;
  logic        in_run;
  int unsigned pkt_left;
  int unsigned byte_pos;
  logic [31:0] partial_pixel;
  logic [31:0] emitted;

  pixel_t      pending_pixels [$];
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 32;
  int unsigned stall_pct     = 70;

  tga_rle_palette_decoder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit decode_word(input logic kind, input logic [7:0] db,
                                     input logic [7:0] idx, input logic [31:0] entry,
                                     output pixel_t px);
    int unsigned width;
    logic [31:0] value;
    logic [31:0] room;
    logic [31:0] rep;
    px = '0;
    if (kind == KIND_PALETTE) begin
      color_table[idx] = entry;
      return 1'b0;
    end
    if (emitted >= set_total) return 1'b0;
    if (set_rle && hdr_pending) begin
      in_run        = db[RUN_FLAG_BIT];
      pkt_left      = int'(db & RUN_COUNT_MASK) + 1;
      hdr_pending   = 1'b0;
      byte_pos      = 0;
      partial_pixel = '0;
      return 1'b0;
    end
    if (set_pixel_bytes == 3'd0) width = 1;
    else if (set_pixel_bytes > PIXEL_BYTES_MAX) width = int'(PIXEL_BYTES_MAX);
    else width = int'(set_pixel_bytes);
    value = partial_pixel | ({24'd0, db} << (8 * byte_pos));
    if (byte_pos + 1 < width) begin
      partial_pixel = {8'd0, value[23:0]};
      byte_pos++;
      return 1'b0;
    end
    byte_pos      = 0;
    partial_pixel = '0;
    if (set_palette) value = color_table[value[7:0]];
    room = set_total - emitted;
    rep  = 1;
    if (set_rle) begin
      if (in_run) begin
        rep      = (pkt_left == 0) ? 1 : pkt_left;
        pkt_left = 0;
      end else if (pkt_left > 0) begin
        pkt_left--;
      end
      if (pkt_left == 0) hdr_pending = 1'b1;
    end
    px.clamped = (rep > room);
    if (px.clamped) rep = room;
    emitted      += rep;
    px.value     = value;
    px.rep_count = rep[7:0];
    px.done      = (emitted == set_total);
    return 1'b1;
  endfunction

  function automatic step_t data_step(input logic [7:0] db);
    step_t s;
    s           = '0;
    s.op        = STEP_WORD;
    s.kind      = KIND_DATA;
    s.data_byte = db;
    return s;
  endfunction

  function automatic step_t load_step(input logic [7:0] idx, input logic [31:0] entry);
    step_t s;
    s           = '0;
    s.op        = STEP_WORD;
    s.kind      = KIND_PALETTE;
    s.pal_index = idx;
    s.value     = entry;
    return s;
  endfunction

  function automatic step_t config_step(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [31:0] data);
    step_t s;
    s           = '0;
    s.op        = STEP_CONFIG;
    s.reg_index = idx;
    s.value     = data;
    return s;
  endfunction

  function automatic step_t pixel_step(input logic [7:0] db, input logic [31:0] value,
                                       input logic [7:0] rep, input logic done,
                                       input logic clamped);
    step_t s;
    s       = data_step(db);
    s.typed = 1'b1;
    s.want  = '{value, rep, done, clamped};
    return s;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endfunction

  task automatic send_word(input logic kind, input logic [7:0] db, input logic [7:0] idx,
                           input logic [31:0] entry, input bit typed, input pixel_t want);
    pixel_t px;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_data_byte     <= db;
    in_palette_index <= idx;
    in_palette_entry <= entry;
    do @(posedge clk); while (in_stall);
    if (decode_word(kind, db, idx, entry, px) || typed)
      pending_pixels.push_back(typed ? want : px);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PIXEL_BYTES:    set_pixel_bytes = data[2:0];
      CFG_RLE_ENABLE:     set_rle = data[0];
      CFG_PALETTE_ENABLE: set_palette = data[0];
      CFG_PIXEL_TOTAL:    set_total = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tga_rle_palette_decoder verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pixel_value, out_repeat_res, out_image_done, out_clamped};
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", '0, got.value);
      end else begin
        want = pending_pixels.pop_front();
        if (got.value !== want.value) note_mismatch("pixel_value", want.value, got.value);
        if (got.rep_count !== want.rep_count)
          note_mismatch("repeat_res", 32'(want.rep_count), 32'(got.rep_count));
        if (got.done !== want.done)
          note_mismatch("image_done", 32'(want.done), 32'(got.done));
        if (got.clamped !== want.clamped)
          note_mismatch("clamped", 32'(want.clamped), 32'(got.clamped));
      end
    end
  end

  initial begin
    step_t       plan [29];
    pixel_t      none;
    logic [7:0]  db;
    logic [2:0]  pb;
    logic [31:0] total;
    int unsigned ignored;
    none = '0;
    plan = '{
      load_step(8'h00, 32'hFFFF_FFFF),
      load_step(8'hFF, 32'h8000_0001),
      data_step(8'h00),
      data_step(8'hFF),
      pixel_step(8'h80, 32'h0080_FF00, 8'd1, 1'b1, 1'b0),
      data_step(8'h12),
      config_step(CFG_PIXEL_TOTAL, 32'hFFFE_0001),
      config_step(CFG_PIXEL_BYTES, 32'd4),
      data_step(8'hFF),
      data_step(8'hFF),
      data_step(8'hFF),
      pixel_step(8'hFF, 32'hFFFF_FFFF, 8'd1, 1'b0, 1'b0),
      config_step(CFG_PIXEL_BYTES, 32'd0),
      pixel_step(8'h00, 32'h0000_0000, 8'd1, 1'b0, 1'b0),
      config_step(CFG_RLE_ENABLE, 32'd1),
      data_step(8'hFF),
      pixel_step(8'h5A, 32'h0000_005A, 8'd128, 1'b0, 1'b0),
      data_step(8'h00),
      data_step(8'h01),
      config_step(CFG_PALETTE_ENABLE, 32'd1),
      data_step(8'h81),
      pixel_step(8'hFF, 32'h8000_0001, 8'd2, 1'b0, 1'b0),
      data_step(8'h01),
      data_step(8'h00),
      data_step(8'hFF),
      config_step(CFG_PIXEL_TOTAL, 32'd140),
      data_step(8'hFF),
      pixel_step(8'h00, 32'hFFFF_FFFF, 8'd4, 1'b1, 1'b1),
      data_step(8'h00)
    };

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_DATA;
    in_data_byte     <= 8'd0;
    in_palette_index <= 8'd0;
    in_palette_entry <= 32'd0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_PIXEL_BYTES;
    cfg_data         <= '0;
    set_pixel_bytes  = PIXEL_BYTES_RESET;
    set_rle          = 1'b0;
    set_palette      = 1'b0;
    set_total        = PIXEL_TOTAL_RESET;
    hdr_pending      = 1'b1;
    in_run           = 1'b0;
    pkt_left         = 0;
    byte_pos         = 0;
    partial_pixel    = '0;
    emitted          = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == STEP_CONFIG) begin
        drain();
        write_reg(plan[i].reg_index, plan[i].value);
      end else begin
        send_word(plan[i].kind, plan[i].data_byte, plan[i].pal_index, plan[i].value,
                  plan[i].typed, plan[i].want);
      end
    end

    // Fill the whole palette so that no lookup can hit an unwritten entry.
    for (int i = 0; i < PALETTE_ENTRIES_DEF; i++)
      send_word(KIND_PALETTE, 8'($urandom()), 8'(i), $urandom(), 1'b0, none);

    for (int s = 0; s < SEGMENTS; s++) begin
      send_idle_pct = (s < 6) ? 32 : (s < 11) ? 70 : 0;
      stall_pct     = (s < 6) ? 70 : (s < 11) ? 32 : 0;
      drain();
      if ($urandom_range(3) == 0) begin
        pb = 3'($urandom_range(3));
        if (pb != 3'd0) pb = pb + 3'd4;
      end else begin
        pb = 3'($urandom_range(4, 1));
      end
      write_reg(CFG_PIXEL_BYTES, ($urandom() & 32'hFFFF_FFF8) | 32'(pb));
      write_reg(CFG_RLE_ENABLE, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(1));
      write_reg(CFG_PALETTE_ENABLE, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(1));
      case ($urandom_range(9))
        0:       total = '1;
        1:       total = 32'hFFFE_0001;
        2:       total = '0;
        default: total = emitted + $urandom_range(400, 1);
      endcase
      write_reg(CFG_PIXEL_TOTAL, total);
      ignored = 0;
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        if (emitted >= set_total) begin
          ignored++;
          if (ignored > 3) break;
        end
        if ($urandom_range(99) < 15) begin
          send_word(KIND_PALETTE, 8'($urandom()), 8'($urandom()), $urandom(), 1'b0, none);
        end else begin
          db = 8'($urandom());
          if (set_rle && hdr_pending && $urandom_range(9) < 7) db[6:0] = 7'($urandom_range(7));
          send_word(KIND_DATA, db, 8'($urandom()), $urandom(), 1'b0, none);
        end
      end
    end

    drain();
    if (mismatches == 0) $display("tga_rle_palette_decoder verification clean");
    else $display("tga_rle_palette_decoder verification failed");
    $finish;
  end

endmodule
